FILE: sv/assert_macros.svh
// Assertion macros shared by the velocity limiter RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define TVL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TVL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tvl_pkg.sv
// Shared types and constants of the twist velocity limiter.
// No dependencies; used by tvl_sqrt, tvl_div and the top level.
package tvl_pkg;

  localparam bit HOLONOMIC = 1'b1;

  localparam int ERR_W  = 20;  // input error fields
  localparam int VEL_W  = 16;  // output command fields
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int MAG_W  = 23;  // rounded gain product magnitude
  localparam int RAD_W  = 48;  // sum of squared linear magnitudes, even width
  localparam int ROOT_W = RAD_W / 2;
  localparam int QUO_W  = MAG_W;
  localparam int DVD_W  = MAG_W + LIM_W + 1;
  localparam int LANES  = 2;   // x and y

  localparam logic [GAIN_W-1:0] TRANS_GAIN_RST = 16'd6144;
  localparam logic [GAIN_W-1:0] ROT_GAIN_RST   = 16'd5120;
  localparam logic [LIM_W-1:0]  MAX_LIN_RST    = 15'd2048;
  localparam logic [LIM_W-1:0]  MIN_LIN_RST    = 15'd410;
  localparam logic [LIM_W-1:0]  MAX_YAW_RST    = 15'd2867;
  localparam logic [LIM_W-1:0]  MIN_YAW_RST    = 15'd0;
  localparam logic [LIM_W-1:0]  IP_MIN_YAW_RST = 15'd0;
  localparam logic [LIM_W-1:0]  IP_THR_RST     = 15'd0;

  typedef enum logic [3:0] {
    CFG_TRANS_GAIN = 4'd0,
    CFG_ROT_GAIN   = 4'd1,
    CFG_MAX_LIN    = 4'd2,
    CFG_MIN_LIN    = 4'd3,
    CFG_MAX_YAW    = 4'd4,
    CFG_MIN_YAW    = 4'd5,
    CFG_IP_MIN_YAW = 4'd6,
    CFG_IP_THR     = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] trans_gain;
    logic [GAIN_W-1:0] rot_gain;
    logic [LIM_W-1:0]  max_lin_speed;
    logic [LIM_W-1:0]  min_lin_speed;
    logic [LIM_W-1:0]  max_yaw_rate;
    logic [LIM_W-1:0]  min_yaw_rate;
    logic [LIM_W-1:0]  in_place_min_yaw;
    logic [LIM_W-1:0]  in_place_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err_x;
    logic signed [ERR_W-1:0] err_y;
    logic signed [ERR_W-1:0] err_yaw;
  } in_beat_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
  } out_beat_t;

  // Sideband that travels with a beat through the root and divider pipes.
  typedef struct packed {
    logic [MAG_W-1:0]        vx_mag;
    logic                    vx_neg;
    logic [MAG_W-1:0]        vy_mag;
    logic                    vy_neg;
    logic                    gt_max;
    logic                    lt_min;
    logic                    in_place;
    logic signed [VEL_W-1:0] yaw;
    logic [ROOT_W-1:0]       root;
  } lin_t;

endpackage

FILE: sv/twist_velocity_limiter_top.sv
// Top level of the twist velocity limiter: config registers, gain and limit stages.
// Depends on tvl_pkg, tvl_sqrt, tvl_div and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  in      | in        | in_valid_i / in_ready_o    | in_data_i  (err_x, err_y, err_yaw)
//  out     | out       | out_valid_o / out_ready_i  | out_data_o (vel_x, vel_y, yaw_rate)
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while the output is not stalled; the pipe runs through the 24-stage square
// root and the two 23-stage dividers (max scaling, then min scaling).
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A waiting output stalls the whole pipe; the first stage still fills if empty.
// cfg_ready_o is always high.
`include "assert_macros.svh"

module twist_velocity_limiter_top import tvl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [3:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int PRD_W = ERR_W + GAIN_W;
  localparam int SQ_W  = 2 * ERR_W;
  localparam int RAW_W = SQ_W + 1;
  localparam int VSQ_W = 2 * MAG_W;
  localparam int SUM_W = VSQ_W + 1;
  localparam int LSQ_W = 2 * LIM_W;
  localparam logic [PRD_W-1:0] HALF_LSB = PRD_W'(2048);

  cfg_t cfg_q;
  logic en;
  logic ld1;

  // ---------------- config ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trans_gain         <= TRANS_GAIN_RST;
      cfg_q.rot_gain           <= ROT_GAIN_RST;
      cfg_q.max_lin_speed      <= MAX_LIN_RST;
      cfg_q.min_lin_speed      <= MIN_LIN_RST;
      cfg_q.max_yaw_rate       <= MAX_YAW_RST;
      cfg_q.min_yaw_rate       <= MIN_YAW_RST;
      cfg_q.in_place_min_yaw   <= IP_MIN_YAW_RST;
      cfg_q.in_place_threshold <= IP_THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_TRANS_GAIN: cfg_q.trans_gain         <= cfg_data_i;
        CFG_ROT_GAIN:   cfg_q.rot_gain           <= cfg_data_i;
        CFG_MAX_LIN:    cfg_q.max_lin_speed      <= cfg_data_i[LIM_W-1:0];
        CFG_MIN_LIN:    cfg_q.min_lin_speed      <= cfg_data_i[LIM_W-1:0];
        CFG_MAX_YAW:    cfg_q.max_yaw_rate       <= cfg_data_i[LIM_W-1:0];
        CFG_MIN_YAW:    cfg_q.min_yaw_rate       <= cfg_data_i[LIM_W-1:0];
        CFG_IP_MIN_YAW: cfg_q.in_place_min_yaw   <= cfg_data_i[LIM_W-1:0];
        CFG_IP_THR:     cfg_q.in_place_threshold <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: magnitudes and products ----------------
  logic             v1_q;
  logic [PRD_W-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic [SQ_W-1:0]  sqx_d, sqy_d, sqx_q, sqy_q;
  logic             nx_d, ny_d, nz_d, nx_q, ny_q, nz_q;

  assign en         = !out_valid_o || out_ready_i;
  assign ld1        = en || !v1_q;
  assign in_ready_o = ld1;

  always_comb begin
    logic [ERR_W-1:0] mx, my, mz;
    nx_d = in_data_i.err_x[ERR_W-1];
    ny_d = in_data_i.err_y[ERR_W-1];
    nz_d = in_data_i.err_yaw[ERR_W-1];
    mx = nx_d ? -in_data_i.err_x   : in_data_i.err_x;
    my = ny_d ? -in_data_i.err_y   : in_data_i.err_y;
    mz = nz_d ? -in_data_i.err_yaw : in_data_i.err_yaw;
    px_d  = PRD_W'(mx) * PRD_W'(cfg_q.trans_gain);
    py_d  = HOLONOMIC ? PRD_W'(my) * PRD_W'(cfg_q.trans_gain) : '0;
    pz_d  = PRD_W'(mz) * PRD_W'(cfg_q.rot_gain);
    sqx_d = SQ_W'(mx) * SQ_W'(mx);
    sqy_d = SQ_W'(my) * SQ_W'(my);
  end

  // ---------------- stage 2: round off the Q.12 gain fraction, raw error energy ----------------
  logic             v2_q;
  logic [MAG_W-1:0] vx2_d, vy2_d, vz2_d, vx2_q, vy2_q, vz2_q;
  logic [RAW_W-1:0] raw2_d, raw2_q;
  logic             nx2_q, ny2_q, nz2_q;

  always_comb begin
    logic [PRD_W-1:0] rx, ry, rz;
    rx = px_q + HALF_LSB;
    ry = py_q + HALF_LSB;
    rz = pz_q + HALF_LSB;
    vx2_d  = rx[12 +: MAG_W];
    vy2_d  = ry[12 +: MAG_W];
    vz2_d  = rz[12 +: MAG_W];
    raw2_d = RAW_W'(sqx_q) + RAW_W'(sqy_q);
  end

  // ---------------- stage 3: squares, in-place test, yaw limits ----------------
  logic             v3_q;
  logic [VSQ_W-1:0] sqvx_d, sqvy_d, sqvx_q, sqvy_q;
  logic             inpl3_d, inpl3_q;
  logic [LIM_W-1:0] zc3_d, zc3_q;
  logic             zn3_d, zn3_q;
  logic [MAG_W-1:0] vx3_q, vy3_q;
  logic             nx3_q, ny3_q;

  always_comb begin
    logic [MAG_W-1:0] z1;
    logic [LSQ_W-1:0] thr_sq;
    sqvx_d  = VSQ_W'(vx2_q) * VSQ_W'(vx2_q);
    sqvy_d  = VSQ_W'(vy2_q) * VSQ_W'(vy2_q);
    thr_sq  = LSQ_W'(cfg_q.in_place_threshold) * LSQ_W'(cfg_q.in_place_threshold);
    inpl3_d = raw2_q < RAW_W'(thr_sq);
    z1      = (vz2_q > MAG_W'(cfg_q.max_yaw_rate)) ? MAG_W'(cfg_q.max_yaw_rate) : vz2_q;
    zc3_d   = (z1 < MAG_W'(cfg_q.min_yaw_rate)) ? '0 : z1[LIM_W-1:0];
    zn3_d   = nz2_q && (zc3_d != '0);
  end

  // ---------------- stage 4: linear energy, final yaw ----------------
  logic             v4_q;
  logic [SUM_W-1:0] sum4_d, sum4_q;
  lin_t             side4_d, side4_q;

  always_comb begin
    logic [LIM_W-1:0] ymag;
    sum4_d = SUM_W'(sqvx_q) + SUM_W'(sqvy_q);
    ymag   = (inpl3_q && zc3_q < cfg_q.in_place_min_yaw) ? cfg_q.in_place_min_yaw : zc3_q;
    side4_d          = '0;
    side4_d.vx_mag   = vx3_q;
    side4_d.vx_neg   = nx3_q;
    side4_d.vy_mag   = vy3_q;
    side4_d.vy_neg   = ny3_q;
    side4_d.in_place = inpl3_q;
    side4_d.yaw      = zn3_q ? -$signed(VEL_W'(ymag)) : $signed(VEL_W'(ymag));
  end

  // ---------------- stage 5: speed limit tests ----------------
  logic             v5_q;
  logic [SUM_W-1:0] sum5_q;
  lin_t             side5_d, side5_q;

  always_comb begin
    logic [LSQ_W-1:0] max_sq, min_sq;
    max_sq = LSQ_W'(cfg_q.max_lin_speed) * LSQ_W'(cfg_q.max_lin_speed);
    min_sq = LSQ_W'(cfg_q.min_lin_speed) * LSQ_W'(cfg_q.min_lin_speed);
    side5_d        = side4_q;
    side5_d.gt_max = sum4_q > SUM_W'(max_sq);
    side5_d.lt_min = (sum4_q != '0) && (sum4_q < SUM_W'(min_sq));
  end

  // ---------------- square root ----------------
  logic              vsq;
  logic [ROOT_W-1:0] root;
  lin_t              side_sq;

  tvl_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v5_q),
    .rad_i  (RAD_W'(sum5_q)),
    .side_i (side5_q),
    .vld_o  (vsq),
    .root_o (root),
    .side_o (side_sq)
  );

  // ---------------- stage 6: max-scaling dividends ----------------
  logic                        v6_q;
  logic [LANES-1:0][DVD_W-1:0] dvd6_d, dvd6_q;
  lin_t                        side6_d, side6_q;

  always_comb begin
    logic [DVD_W-1:0] half;
    half         = DVD_W'(root >> 1);
    side6_d      = side_sq;
    side6_d.root = root;
    dvd6_d[0] = DVD_W'(side_sq.vx_mag) * DVD_W'(cfg_q.max_lin_speed) + half;
    dvd6_d[1] = DVD_W'(side_sq.vy_mag) * DVD_W'(cfg_q.max_lin_speed) + half;
  end

  logic                        vd1;
  logic [LANES-1:0][QUO_W-1:0] q1;
  lin_t                        side_d1;

  tvl_div u_div_max (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v6_q),
    .dvd_i  (dvd6_q),
    .den_i  (side6_q.root),
    .side_i (side6_q),
    .vld_o  (vd1),
    .quo_o  (q1),
    .side_o (side_d1)
  );

  // ---------------- stage 7: apply max, min-scaling dividends ----------------
  logic                        v7_q;
  logic [LANES-1:0][DVD_W-1:0] dvd7_d, dvd7_q;
  lin_t                        side7_d, side7_q;

  always_comb begin
    logic [DVD_W-1:0] half;
    half    = DVD_W'(side_d1.root >> 1);
    side7_d = side_d1;
    if (side_d1.gt_max) begin
      side7_d.vx_mag = q1[0];
      side7_d.vy_mag = q1[1];
    end
    dvd7_d[0] = DVD_W'(side7_d.vx_mag) * DVD_W'(cfg_q.min_lin_speed) + half;
    dvd7_d[1] = DVD_W'(side7_d.vy_mag) * DVD_W'(cfg_q.min_lin_speed) + half;
  end

  logic                        vd2;
  logic [LANES-1:0][QUO_W-1:0] q2;
  lin_t                        side_d2;

  tvl_div u_div_min (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v7_q),
    .dvd_i  (dvd7_q),
    .den_i  (side7_q.root),
    .side_i (side7_q),
    .vld_o  (vd2),
    .quo_o  (q2),
    .side_o (side_d2)
  );

  // ---------------- output register ----------------
  function automatic logic signed [VEL_W-1:0] sat16(input logic neg,
                                                    input logic [MAG_W-1:0] mag);
    logic [VEL_W-1:0] res;
    if (neg) begin
      res = (mag >= MAG_W'(32768)) ? 16'h8000 : 16'h0000 - mag[VEL_W-1:0];
    end else begin
      res = (mag > MAG_W'(32767)) ? 16'h7fff : mag[VEL_W-1:0];
    end
    return $signed(res);
  endfunction

  logic      out_valid_q;
  out_beat_t out_d, out_q;

  always_comb begin
    logic [MAG_W-1:0] fx, fy;
    fx = side_d2.lt_min ? q2[0] : side_d2.vx_mag;
    fy = side_d2.lt_min ? q2[1] : side_d2.vy_mag;
    if (side_d2.in_place) begin
      fx = '0;
      fy = '0;
    end
    out_d.vel_x    = sat16(side_d2.vx_neg, fx);
    out_d.vel_y    = sat16(side_d2.vy_neg, fy);
    out_d.yaw_rate = side_d2.yaw;
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (en) begin
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        v4_q        <= v3_q;
        v5_q        <= v4_q;
        v6_q        <= vsq;
        v7_q        <= vd1;
        out_valid_q <= vd2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      nx_q  <= nx_d;
      ny_q  <= ny_d;
      nz_q  <= nz_d;
    end
    if (en) begin
      vx2_q   <= vx2_d;
      vy2_q   <= vy2_d;
      vz2_q   <= vz2_d;
      raw2_q  <= raw2_d;
      nx2_q   <= nx_q;
      ny2_q   <= ny_q;
      nz2_q   <= nz_q;
      sqvx_q  <= sqvx_d;
      sqvy_q  <= sqvy_d;
      inpl3_q <= inpl3_d;
      zc3_q   <= zc3_d;
      zn3_q   <= zn3_d;
      vx3_q   <= vx2_q;
      vy3_q   <= vy2_q;
      nx3_q   <= nx2_q;
      ny3_q   <= ny2_q;
      sum4_q  <= sum4_d;
      side4_q <= side4_d;
      sum5_q  <= sum4_q;
      side5_q <= side5_d;
      dvd6_q  <= dvd6_d;
      side6_q <= side6_d;
      dvd7_q  <= dvd7_d;
      side7_q <= side7_d;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `TVL_ASSERT_NEXT(a_inplace_zero, en && vd2 && side_d2.in_place,
                   out_q.vel_x == '0 && out_q.vel_y == '0, "in-place beat with linear motion")

  `TVL_ASSERT(a_yaw_range, !out_valid_q || out_q.yaw_rate != 16'sh8000,
              "yaw rate beyond 15-bit limit")

  `TVL_ASSERT_NEXT(a_max_bound,
                   en && vd2 && side_d2.gt_max && !side_d2.lt_min && !side_d2.in_place,
                   out_q.vel_x <= $signed({1'b0, cfg_q.max_lin_speed}) &&
                   out_q.vel_x >= -$signed({1'b0, cfg_q.max_lin_speed}),
                   "max-scaled speed above limit")

  `TVL_ASSERT_NEXT(a_stall_hold, out_valid_q && !out_ready_i && v1_q,
                   v1_q && out_valid_q, "beat dropped during output stall")

endmodule

FILE: sv/tvl_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on tvl_pkg (widths, lin_t sideband).
module tvl_sqrt import tvl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  lin_t              side_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output lin_t              side_o
);

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] vld_q;
  logic [RAD_W-1:0]  rad_in  [ROOT_W];
  logic [REM_W-1:0]  rem_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [RAD_W-1:0]  rad_d   [ROOT_W];
  logic [REM_W-1:0]  rem_d   [ROOT_W];
  logic [ROOT_W-1:0] root_d  [ROOT_W];
  logic [RAD_W-1:0]  rad_q   [ROOT_W];
  logic [REM_W-1:0]  rem_q   [ROOT_W];
  logic [ROOT_W-1:0] root_q  [ROOT_W];
  lin_t              side_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rad_in[s]  = rad_i;
      assign rem_in[s]  = '0;
      assign root_in[s] = '0;
    end else begin : g_next
      assign rad_in[s]  = rad_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign root_in[s] = root_q[s-1];
    end

    always_comb begin
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      cur   = {rem_in[s], rad_in[s][RAD_W-1 -: 2]};
      trial = (REM_W+2)'({root_in[s], 2'b01});
      if (cur >= trial) begin
        rem_d[s]  = REM_W'(cur - trial);
        root_d[s] = {root_in[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[s]  = cur[REM_W-1:0];
        root_d[s] = {root_in[s][ROOT_W-2:0], 1'b0};
      end
      rad_d[s] = {rad_in[s][RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < ROOT_W; s++) begin
        rad_q[s]  <= rad_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
      side_q[0] <= side_i;
      for (int s = 1; s < ROOT_W; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

FILE: sv/tvl_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on tvl_pkg; the quotient must fit in QUO_W bits.
module tvl_div import tvl_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [LANES-1:0][DVD_W-1:0]  dvd_i,
  input  logic [ROOT_W-1:0]            den_i,
  input  lin_t                         side_i,
  output logic                         vld_o,
  output logic [LANES-1:0][QUO_W-1:0]  quo_o,
  output lin_t                         side_o
);

  localparam int REM_W = ROOT_W + 1;

  logic [QUO_W-1:0]                    vld_q;
  logic [LANES-1:0][REM_W-1:0]         rem_in [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]         lo_in  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]         quo_in [QUO_W];
  logic [ROOT_W-1:0]                   den_in [QUO_W];
  logic [LANES-1:0][REM_W-1:0]         rem_d  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]         lo_d   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]         quo_d  [QUO_W];
  logic [LANES-1:0][REM_W-1:0]         rem_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]         lo_q   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]         quo_q  [QUO_W];
  logic [ROOT_W-1:0]                   den_q  [QUO_W];
  lin_t                                side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    if (s == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        // upper dividend bits are already below the divisor
        assign rem_in[s][l] = REM_W'(dvd_i[l][DVD_W-1:QUO_W]);
        assign lo_in[s][l]  = dvd_i[l][QUO_W-1:0];
        assign quo_in[s][l] = '0;
      end
      assign den_in[s] = den_i;
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign lo_in[s]  = lo_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign den_in[s] = den_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_step
      always_comb begin
        logic [REM_W:0] cur;
        logic [REM_W:0] den;
        logic           take;
        cur  = {rem_in[s][l], lo_in[s][l][QUO_W-1]};
        den  = (REM_W+1)'(den_in[s]);
        take = (cur >= den);
        rem_d[s][l] = take ? REM_W'(cur - den) : cur[REM_W-1:0];
        quo_d[s][l] = {quo_in[s][l][QUO_W-2:0], take};
        lo_d[s][l]  = {lo_in[s][l][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QUO_W; s++) begin
        rem_q[s] <= rem_d[s];
        lo_q[s]  <= lo_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_in[s];
      end
      side_q[0] <= side_i;
      for (int s = 1; s < QUO_W; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign quo_o  = quo_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule
